### hw/rtl/itra_pkg.sv
// ----------------------------------------------------------------------------
// itra_pkg
// Shared constants and the digit-to-character mapping for the radix converter.
// ----------------------------------------------------------------------------
package itra_pkg;

  localparam int unsigned STEP_BITS = 4;

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;

  localparam logic [6:0] ASCII_MINUS = 7'h2D;
  localparam logic [6:0] ASCII_ZERO  = 7'h30;
  localparam logic [6:0] ASCII_LOWER = 7'h61;
  localparam logic [6:0] ASCII_UPPER = 7'h41;

  localparam int unsigned FLAG_UNSIGNED = 0;
  localparam int unsigned FLAG_LOWER    = 1;

  function automatic logic [6:0] digit_char(input logic [3:0] digit, input logic lower);
    logic [6:0] d;
    d = {3'b000, digit};
    if (digit < 4'd10) begin
      digit_char = ASCII_ZERO + d;
    end else if (lower) begin
      digit_char = ASCII_LOWER + d - 7'd10;
    end else begin
      digit_char = ASCII_UPPER + d - 7'd10;
    end
  endfunction

endpackage

### hw/rtl/integer_to_radix_ascii_core.sv
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_core
// Converts one integer word to ASCII text in radix 2..16, most significant
// character first, with a last flag on the final character.
// ----------------------------------------------------------------------------
// Usage: one word is taken on num_valid/num_ready, then num_ready stays low
// until its last character has been loaded into the output register. Digits
// come from a shared long-division unit that retires 4 dividend bits per
// cycle, so each digit is one full pass over the dividend. The sign state
// comes next, whether a minus is sent or not, and the digits are then read
// back from the digit store through a read state and an output state per
// character. Only the low NUM_WIDTH bits of num_bits are used.
module integer_to_radix_ascii_core #(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        num_valid,
  output logic        num_ready,
  input  logic [31:0] num_bits,
  input  logic [4:0]  radix,
  input  logic [1:0]  format_flags,
  output logic        char_valid,
  input  logic        char_ready,
  output logic [6:0]  char_code,
  output logic        last_char
);

  localparam int unsigned STEPS = (NUM_WIDTH + itra_pkg::STEP_BITS - 1) / itra_pkg::STEP_BITS;
  localparam int unsigned PW    = STEPS * itra_pkg::STEP_BITS;
  localparam int unsigned SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned CW    = $clog2(NUM_WIDTH + 1);
  localparam int unsigned AW    = $clog2(NUM_WIDTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SIGN = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]           state;
  logic [PW-1:0]        quot;
  logic [PW-1:0]        quot_next;
  logic [4:0]           rem;
  logic [4:0]           rem_next;
  logic [4:0]           rad;
  logic                 lower;
  logic                 minus;
  logic [SW-1:0]        step;
  logic [CW-1:0]        count;
  logic [3:0]           rd_digit;
  logic [3:0]           store [NUM_WIDTH];

  logic [63:0]          num_ext;
  logic [NUM_WIDTH-1:0] word;
  logic [NUM_WIDTH-1:0] word_neg;
  logic                 neg;
  logic [4:0]           rad_in;
  logic                 slot_free;
  logic                 char_load;
  logic                 last_step;
  logic [CW-1:0]        count_dec;

  assign num_ext   = {32'd0, num_bits};
  assign word      = num_ext[NUM_WIDTH-1:0];
  assign word_neg  = {NUM_WIDTH{1'b0}} - word;
  assign neg       = !format_flags[itra_pkg::FLAG_UNSIGNED] && word[NUM_WIDTH-1];
  assign rad_in    = (radix < itra_pkg::RADIX_MIN) ? itra_pkg::RADIX_MIN :
                     (radix > itra_pkg::RADIX_MAX) ? itra_pkg::RADIX_MAX : radix;
  assign slot_free = !char_valid || char_ready;
  assign char_load = slot_free && ((state == ST_SIGN && minus) || state == ST_OUT);
  assign last_step = (step == SW'(STEPS - 1));
  assign count_dec = count - CW'(1);
  assign num_ready = (state == ST_IDLE);

  // four restoring long-division steps on the small remainder
  always_comb begin
    quot_next = quot;
    rem_next  = rem;
    for (int i = 0; i < int'(itra_pkg::STEP_BITS); i++) begin
      rem_next  = {rem_next[3:0], quot_next[PW-1]};
      quot_next = {quot_next[PW-2:0], 1'b0};
      if (rem_next >= rad) begin
        rem_next     = rem_next - rad;
        quot_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV && last_step) begin
      store[count[AW-1:0]] <= rem_next[3:0];
    end
    if (state == ST_RD) begin
      rd_digit <= store[count_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_valid <= 1'b0;
      count      <= '0;
      step       <= '0;
      minus      <= 1'b0;
    end else begin
      if (char_load) begin
        char_valid <= 1'b1;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (num_valid) begin
            quot  <= neg ? PW'(word_neg) : PW'(word);
            minus <= neg;
            rad   <= rad_in;
            lower <= format_flags[itra_pkg::FLAG_LOWER];
            rem   <= '0;
            step  <= '0;
            count <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (last_step) begin
            count <= count + CW'(1);
            step  <= '0;
            rem   <= '0;
            quot  <= quot_next;
            if (quot_next == '0) begin
              state <= ST_SIGN;
            end
          end else begin
            step <= step + SW'(1);
            rem  <= rem_next;
            quot <= quot_next;
          end
        end
        ST_SIGN: begin
          if (!minus) begin
            state <= ST_RD;
          end else if (slot_free) begin
            char_code <= itra_pkg::ASCII_MINUS;
            last_char <= 1'b0;
            state     <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (slot_free) begin
            char_code <= itra_pkg::digit_char(rd_digit, lower);
            last_char <= (count == CW'(1));
            count     <= count_dec;
            state     <= (count == CW'(1)) ? ST_IDLE : ST_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
